// File: design/rc4_stream_cipher_assert.svh
// Assertion macros shared by the RC4 cipher RTL.
// No dependencies. Setting NO_ASSERTIONS removes every check.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RC4_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RC4_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: design/rc4_pkg.sv
// Types and constants of the RC4 stream cipher.
// No dependencies; imported by rc4_stream_cipher.
package rc4_pkg;

    typedef logic [7:0] byte_t;

    localparam int TABLE_DEPTH   = 256;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;

    localparam byte_t LAST_ENTRY = 8'(TABLE_DEPTH - 1);

    // Command carried on the input tuser.
    localparam logic CMD_KEY_SCHED = 1'b0;
    localparam logic CMD_DATA      = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'(MAX_KEY_BYTES);

    // Key length as used by the schedule: zero counts as one, large values saturate.
    function automatic logic [KEY_LEN_W-1:0] eff_key_len(input logic [KEY_LEN_W-1:0] len);
        logic [KEY_LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = 5'd1;
        end else if (len > KEY_LEN_RESET) begin
            res = KEY_LEN_RESET;
        end
        return res;
    endfunction

endpackage

// File: design/rc4_stream_cipher.sv
// Data byte: accepted in idle, then RD_J, WR_I, WR_J and OUT; OUT loads the output register
// once it is free. No new byte is taken before idle again, since the permutation RAM has a
// single read and write port. Key schedule: a fill pass, then 256 swaps through RD_I, RD_J,
// WR_I and WR_J. Reset (aresetn low, synchronous): a fill pass writes the identity permutation,
// s_axis_tready stays low meanwhile; configuration writes are taken whenever out of reset.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rc4_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] cmd
    // Result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata   // [7:0] cipher_byte, [15:8] key_byte
);
    import rc4_pkg::*;

    localparam logic [2:0] ST_FILL = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD_I = 3'd2;
    localparam logic [2:0] ST_RD_J = 3'd3;
    localparam logic [2:0] ST_WR_I = 3'd4;
    localparam logic [2:0] ST_WR_J = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Permutation memory, one read and one write port, registered read data.
    byte_t perm_mem [TABLE_DEPTH];
    byte_t rdata_reg;
    byte_t raddr;
    byte_t waddr;
    byte_t wdata;
    logic  mem_we;

    logic [2:0]                 state_reg, state_next;
    logic                       ks_mode_reg, ks_mode_next;
    byte_t                      cnt_reg, cnt_next;
    byte_t                      i_reg, i_next;
    byte_t                      j_reg, j_next;
    byte_t                      pos_reg, pos_next;
    byte_t                      si_reg, si_next;
    byte_t                      sj_reg, sj_next;
    byte_t                      t_reg, t_next;
    byte_t                      ks_reg, ks_next;
    byte_t                      data_reg, data_next;
    logic [KEY_IDX_W-1:0]       kidx_reg, kidx_next;
    logic                       m_valid_reg, m_valid_next;
    logic [15:0]                m_data_reg, m_data_next;

    logic [CFG_DATA_W-1:0]      key_low_reg;
    logic [CFG_DATA_W-1:0]      key_high_reg;
    logic [KEY_LEN_W-1:0]       key_len_reg;

    logic [KEY_LEN_W-1:0]       eff_len;
    logic [2*CFG_DATA_W-1:0]    key_all;
    byte_t                      key_sel;
    byte_t                      j_add;
    logic                       in_xfer;
    logic                       out_free;

    assign cfg_ready     = aresetn;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Key byte for the current schedule step.
    assign eff_len = eff_key_len(key_len_reg);
    assign key_all = {key_high_reg, key_low_reg};
    assign key_sel = key_all[{kidx_reg, 3'b000} +: 8];
    assign j_add   = ks_mode_reg ? key_sel : 8'd0;

    // Memory array.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            perm_mem[waddr] <= wdata;
        end
        rdata_reg <= perm_mem[raddr];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= KEY_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KEY_LOW:    key_low_reg  <= cfg_data;
                REG_KEY_HIGH:   key_high_reg <= cfg_data;
                REG_KEY_LENGTH: key_len_reg  <= cfg_data[KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: fill, read-modify-write swap, keystream lookup.
    always_comb begin
        state_next   = state_reg;
        ks_mode_next = ks_mode_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        t_next       = t_reg;
        ks_next      = ks_reg;
        data_next    = data_reg;
        kidx_next    = kidx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        raddr        = '0;
        waddr        = '0;
        wdata        = '0;
        mem_we       = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_FILL: begin
                mem_we   = 1'b1;
                waddr    = cnt_reg;
                wdata    = cnt_reg;
                cnt_next = cnt_reg + 8'd1;
                if (cnt_reg == LAST_ENTRY) begin
                    state_next = ks_mode_reg ? ST_RD_I : ST_IDLE;
                end
            end
            ST_IDLE: begin
                raddr = i_reg + 8'd1;
                if (in_xfer) begin
                    if (s_axis_tuser == CMD_KEY_SCHED) begin
                        state_next   = ST_FILL;
                        ks_mode_next = 1'b1;
                        cnt_next     = '0;
                        j_next       = '0;
                        kidx_next    = '0;
                    end else begin
                        state_next = ST_RD_J;
                        i_next     = i_reg + 8'd1;
                        pos_next   = i_reg + 8'd1;
                        data_next  = s_axis_tdata;
                    end
                end
            end
            ST_RD_I: begin
                raddr      = cnt_reg;
                pos_next   = cnt_reg;
                state_next = ST_RD_J;
            end
            ST_RD_J: begin
                si_next    = rdata_reg;
                j_next     = j_reg + rdata_reg + j_add;
                raddr      = j_next;
                state_next = ST_WR_I;
            end
            ST_WR_I: begin
                sj_next    = rdata_reg;
                mem_we     = 1'b1;
                waddr      = pos_reg;
                wdata      = rdata_reg;
                t_next     = si_reg + rdata_reg;
                raddr      = t_next;
                state_next = ST_WR_J;
            end
            ST_WR_J: begin
                mem_we = 1'b1;
                waddr  = j_reg;
                wdata  = si_reg;
                if (ks_mode_reg) begin
                    cnt_next = cnt_reg + 8'd1;
                    if ({1'b0, kidx_reg} + 5'd1 >= eff_len) begin
                        kidx_next = '0;
                    end else begin
                        kidx_next = kidx_reg + 1'b1;
                    end
                    if (cnt_reg == LAST_ENTRY) begin
                        state_next   = ST_IDLE;
                        ks_mode_next = 1'b0;
                        i_next       = '0;
                        j_next       = '0;
                    end else begin
                        state_next = ST_RD_I;
                    end
                end else begin
                    // The lookup read was issued before both swap writes landed.
                    if (t_reg == j_reg) begin
                        ks_next = si_reg;
                    end else if (t_reg == pos_reg) begin
                        ks_next = sj_reg;
                    end else begin
                        ks_next = rdata_reg;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {ks_reg, data_reg ^ ks_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            ks_mode_reg <= 1'b0;
            cnt_reg     <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            kidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ks_mode_reg <= ks_mode_next;
            cnt_reg     <= cnt_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            kidx_reg    <= kidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        t_reg      <= t_next;
        ks_reg     <= ks_next;
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

    // Checks.
    `RC4_ASSERT_IMPL(a_write_states, aclk, aresetn, mem_we,
        (state_reg == ST_FILL) || (state_reg == ST_WR_I) || (state_reg == ST_WR_J),
        "table written outside a write state")
    `RC4_ASSERT_NEXT(a_valid_source, aclk, aresetn,
        !m_valid_reg && (state_reg != ST_OUT), !m_valid_reg,
        "result raised outside the output state")
    `RC4_ASSERT_NEXT(a_ks_end, aclk, aresetn,
        ks_mode_reg && (state_reg == ST_WR_J) && (cnt_reg == LAST_ENTRY),
        (i_reg == '0) && (j_reg == '0) && (state_reg == ST_IDLE),
        "indices not cleared after key schedule")
    `RC4_ASSERT_IMPL(a_key_idx, aclk, aresetn, ks_mode_reg, {1'b0, kidx_reg} < eff_len,
        "key index beyond key length")

endmodule
